>>> design/image_shear_address_map_assert.svh
// ----------------------------------------------------------------------------
// Image shear address map - assertion macros
// Concurrent assertion shorthands that sample on i_clk and are disabled
// while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IMAGE_SHEAR_ADDRESS_MAP_ASSERT_SVH
`define IMAGE_SHEAR_ADDRESS_MAP_ASSERT_SVH

// Check that expr holds at every clock edge.
`define ISAM_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("isam: assertion failed");

// Check that cons holds at every clock edge where ante holds.
`define ISAM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("isam: assertion failed");

`endif

>>> design/isam_pkg.sv
// ----------------------------------------------------------------------------
// Image shear address map - package
// Field widths, register indexes and the payload types of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package isam_pkg;

    localparam int COORD_W     = 17;
    localparam int AMT_W       = 17;
    localparam int SIZE_W      = 13;
    localparam int OUT_W       = 12;
    localparam int Q_W         = AMT_W;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_DIM_DEF = 4096;
    localparam int DIV_STAGES  = Q_W;
    localparam int LATENCY     = DIV_STAGES + 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTICAL = 2'd0,
        CFG_AMOUNT   = 2'd1,
        CFG_WIDTH    = 2'd2,
        CFG_HEIGHT   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] dest_row;
        logic [COORD_W-1:0] dest_col;
    } t_pix_in;

    typedef struct packed {
        logic [OUT_W-1:0] src_row;
        logic [OUT_W-1:0] src_col;
        logic             is_background;
    } t_pix_out;

endpackage

`default_nettype wire

>>> design/image_shear_address_map.sv
// ----------------------------------------------------------------------------
// Image shear address map
// Maps each destination pixel of a sheared frame to its source pixel, or
// flags it as zero background.
//
// Command channel: a coordinate pair on i_cmd is taken at a rising edge with
// start high and busy low. busy stays low, so one pair can enter every cycle.
// Result channel: o_strobe marks o_result for exactly one cycle; the receiver
// always takes it and cannot stall the block.
// Pipeline: the path from i_cmd to o_result runs through one multiply stage and
// a 17-stage restoring divider, one quotient bit per stage. Throughput: one
// pixel per cycle.
// Configuration: i_cfg_valid/o_cfg_ready write channel, o_cfg_ready always
// high; write only while no pixel is in flight. Index 0 shear_vertical,
// 1 shear_amount, 2 src_width, 3 src_height.
// Reset: synchronous, active low; empties the pipeline and restores the
// registers to horizontal mode, zero amount, 1 x 1 source.
// ----------------------------------------------------------------------------
`default_nettype none

module image_shear_address_map #(
    parameter int MAX_DIM = isam_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  isam_pkg::t_pix_in                i_cmd,
    output logic                             o_strobe,
    output isam_pkg::t_pix_out               o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  isam_pkg::t_cfg_idx               i_cfg_index,
    input  logic [isam_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import isam_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int PROD_W = AMT_W + DIM_W;

    typedef struct packed {
        logic [DIM_W-1:0]   rem;
        logic [Q_W-1:0]     low;
        logic [Q_W-1:0]     q;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               in_frame;
    } t_div;

    logic               r_vertical;
    logic [AMT_W-1:0]   r_amount;
    logic [SIZE_W-1:0]  r_width;
    logic [SIZE_W-1:0]  r_height;

    logic               r_s1_valid;
    logic [COORD_W-1:0] r_s1_row;
    logic [COORD_W-1:0] r_s1_col;

    logic               r_s2_valid;
    logic [COORD_W-1:0] r_s2_row;
    logic [COORD_W-1:0] r_s2_col;
    logic               r_s2_in_frame;
    logic [DIM_W-1:0]   r_s2_num;

    logic [DIV_STAGES:0] r_div_vld;
    t_div                r_div [DIV_STAGES+1];
    t_div                n_div [DIV_STAGES+1];

    logic               r_s21_valid;
    logic               r_s21_in_frame;
    logic [COORD_W-1:0] r_s21_row;
    logic [COORD_W-1:0] r_s21_col;
    logic [COORD_W:0]   r_s21_diff;

    logic               r_out_valid;
    t_pix_out           r_out;
    t_pix_out           n_out;

    logic               amt_neg;
    logic               amt_pos;
    logic [AMT_W-1:0]   abs_a;
    logic [DIM_W-1:0]   dim_w;
    logic [DIM_W-1:0]   dim_h;
    logic [DIM_W-1:0]   div_d;
    logic               s1_in_frame;
    logic [DIM_W-1:0]   s1_num;
    logic [PROD_W-1:0]  s2_prod;
    logic [COORD_W-1:0] s20_shift;
    logic [COORD_W:0]   s20_diff;
    logic [DIM_W-1:0]   s21_lim;
    logic               s21_hit;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertical <= 1'b0;
            r_amount   <= '0;
            r_width    <= SIZE_W'(1);
            r_height   <= SIZE_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VERTICAL: r_vertical <= i_cfg_data[0];
                CFG_AMOUNT:   r_amount   <= i_cfg_data[AMT_W-1:0];
                CFG_WIDTH:    r_width    <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[SIZE_W-1:0];
                default:      r_vertical <= r_vertical;
            endcase
        end
    end

    always_comb begin
        amt_neg = r_amount[AMT_W-1];
        amt_pos = !amt_neg && (r_amount != '0);
        abs_a   = amt_neg ? AMT_W'(-r_amount) : r_amount;
        dim_w   = clamp_dim(r_width);
        dim_h   = clamp_dim(r_height);
        div_d   = r_vertical ? dim_w : dim_h;
    end

    // stage 1: transfer in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_row <= i_cmd.dest_row;
        r_s1_col <= i_cmd.dest_col;
    end

    // stage 2: frame test and dividend factor
    always_comb begin
        if (r_vertical) begin
            s1_in_frame = r_s1_col < COORD_W'(dim_w);
            s1_num      = amt_neg ? DIM_W'(dim_w - DIM_W'(1) - DIM_W'(r_s1_col))
                                  : DIM_W'(r_s1_col);
        end else begin
            s1_in_frame = r_s1_row < COORD_W'(dim_h);
            s1_num      = DIM_W'(r_s1_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_row      <= r_s1_row;
        r_s2_col      <= r_s1_col;
        r_s2_in_frame <= s1_in_frame;
        r_s2_num      <= s1_num;
    end

    // stage 3: product, loaded into the divider
    assign s2_prod = PROD_W'(abs_a) * PROD_W'(r_s2_num);

    always_comb begin
        n_div[0].rem      = s2_prod[PROD_W-1:Q_W];
        n_div[0].low      = s2_prod[Q_W-1:0];
        n_div[0].q        = '0;
        n_div[0].row      = r_s2_row;
        n_div[0].col      = r_s2_col;
        n_div[0].in_frame = r_s2_in_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_vld <= '0;
        end else begin
            r_div_vld <= {r_div_vld[DIV_STAGES-1:0], r_s2_valid};
        end
    end

    for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            r_div[k] <= n_div[k];
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
        logic [DIM_W:0] trial;
        logic           ge;
        always_comb begin
            trial = {r_div[k].rem, r_div[k].low[Q_W-1]};
            ge    = trial >= {1'b0, div_d};
            n_div[k+1]     = r_div[k];
            n_div[k+1].rem = ge ? DIM_W'(trial - {1'b0, div_d}) : trial[DIM_W-1:0];
            n_div[k+1].low = {r_div[k].low[Q_W-2:0], 1'b0};
            n_div[k+1].q   = {r_div[k].q[Q_W-2:0], ge};
        end
    end

    // stage 21: shift and offset into the source frame
    always_comb begin
        s20_shift = amt_pos ? COORD_W'(r_amount - r_div[DIV_STAGES].q)
                            : COORD_W'(r_div[DIV_STAGES].q);
        if (r_vertical) begin
            s20_diff = {1'b0, r_div[DIV_STAGES].row} - {1'b0, COORD_W'(r_div[DIV_STAGES].q)};
        end else begin
            s20_diff = {1'b0, r_div[DIV_STAGES].col} - {1'b0, s20_shift};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s21_valid <= 1'b0;
        end else begin
            r_s21_valid <= r_div_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s21_in_frame <= r_div[DIV_STAGES].in_frame;
        r_s21_row      <= r_div[DIV_STAGES].row;
        r_s21_col      <= r_div[DIV_STAGES].col;
        r_s21_diff     <= s20_diff;
    end

    // stage 22: range check and result register
    always_comb begin
        s21_lim = r_vertical ? dim_h : dim_w;
        s21_hit = r_s21_in_frame && !r_s21_diff[COORD_W]
                  && (r_s21_diff[COORD_W-1:0] < COORD_W'(s21_lim));
        n_out.is_background = !s21_hit;
        if (!s21_hit) begin
            n_out.src_row = '0;
            n_out.src_col = '0;
        end else if (r_vertical) begin
            n_out.src_row = r_s21_diff[OUT_W-1:0];
            n_out.src_col = r_s21_col[OUT_W-1:0];
        end else begin
            n_out.src_row = r_s21_row[OUT_W-1:0];
            n_out.src_col = r_s21_diff[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s21_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

>>> design/isam_checker.sv
// ----------------------------------------------------------------------------
// Image shear address map - port checker
// Watches the ports of the top level for result timing and field rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "image_shear_address_map_assert.svh"

module isam_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  isam_pkg::t_pix_in                i_cmd,
    input  logic                             o_strobe,
    input  isam_pkg::t_pix_out               o_result,
    input  logic                             i_cfg_valid,
    input  logic                             o_cfg_ready,
    input  isam_pkg::t_cfg_idx               i_cfg_index,
    input  logic [isam_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import isam_pkg::*;

    logic r_vertical;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertical <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_VERTICAL)) begin
            r_vertical <= i_cfg_data[0];
        end
    end

    `ISAM_ASSERT_ALWAYS(a_bg_zero, !(o_strobe && o_result.is_background) || (o_result.src_row == '0 && o_result.src_col == '0))

    `ISAM_ASSERT_IMPL(a_strobe_lat, o_strobe, $past(start && !busy, LATENCY))

    `ISAM_ASSERT_IMPL(a_vert_col, o_strobe && !o_result.is_background && r_vertical, o_result.src_col == OUT_W'($past(i_cmd.dest_col, LATENCY)))

    `ISAM_ASSERT_IMPL(a_horz_row, o_strobe && !o_result.is_background && !r_vertical, o_result.src_row == OUT_W'($past(i_cmd.dest_row, LATENCY)))

endmodule

bind image_shear_address_map isam_checker u_isam_checker (.*);

`default_nettype wire
